// ----- src/sec_pkg.sv -----
// ---------------------------------------------------------------------------
// sec_pkg: shared types for the string escape collapser
// Beat layouts, escape modes, error codes and the decode helpers used by
// the front end, the command queue and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package sec_pkg;

   // Default depth of the command queue between front and back end.
   localparam int SEC_QUEUE_DEPTH = 2;

   // Characters that steer the decoder.
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_C         = 8'h63;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_P         = 8'h70;
   localparam logic [7:0] CHAR_O         = 8'h6F;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;

   // Control codes produced by the simple escapes.
   localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
   localparam logic [7:0] CODE_RETURN    = 8'h0D;
   localparam logic [7:0] CODE_TAB       = 8'h09;
   localparam logic [7:0] CODE_CTRL_R    = 8'h0F;
   localparam logic [7:0] CODE_CTRL_P    = 8'h10;
   localparam logic [7:0] CODE_CTRL_O    = 8'h11;

   // Escape decoder state.
   typedef enum logic [2:0] {
      MODE_TEXT = 3'd0,
      MODE_ESC  = 3'd1,
      MODE_HEX0 = 3'd2,
      MODE_HEX1 = 3'd3,
      MODE_CTRL = 3'd4
   } mode_type;

   // Error codes reported on status beats.
   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_INCOMPLETE = 2'd1,
      ERR_BAD_HEX    = 2'd2
   } err_type;

   // Input beat.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       string_done;
      err_type    error_code;
   } rsp_type;

   // One decoded command: a single result, or the three-byte pass-through
   // of an unknown control escape.
   typedef struct packed {
      logic       triple;
      logic [7:0] data;
      logic       byte_valid;
      logic       string_done;
      err_type    error_code;
   } cmd_type;

   // Hex digit value; letters are folded to lower case first.
   function automatic logic [7:0] hex_value(input logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (c >= 8'd65 && c <= 8'd90) begin
         c = c + 8'd32;
      end
      if (c >= 8'd97 && c <= 8'd127) begin
         return c - 8'd87;
      end
      return c - 8'd48;
   endfunction

   // Control code for the digits 0..9 of a control escape.
   function automatic logic [7:0] ctrl_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0: code = 8'h01;
         4'd1: code = 8'h02;
         4'd2: code = 8'h03;
         4'd3: code = 8'h04;
         4'd4: code = 8'h05;
         4'd5: code = 8'h06;
         4'd6: code = 8'h07;
         4'd7: code = 8'h0B;
         4'd8: code = 8'h0C;
         4'd9: code = 8'h0E;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ----- src/sec_front.sv -----
// ---------------------------------------------------------------------------
// sec_front: escape classifier
// Accepts raw bytes, tracks the escape state and turns each byte into at
// most one command for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module sec_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_wr_data,
   input  wire logic             fire,
   input  wire sec_pkg::req_type req_data,
   output logic                  push,
   output sec_pkg::cmd_type      push_cmd
);
   import sec_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [7:0] first_hex_ff, first_hex_in;
   logic       aborted_ff, aborted_in;
   logic       strict_ff;

   logic       eos;
   logic [7:0] b;
   logic [7:0] digit;
   logic [7:0] out_val;
   logic       emit;
   logic       triple;
   logic       cut;
   err_type    err;
   logic       has_result;

   assign eos = req_data.end_of_string;
   assign b   = req_data.in_byte;

   // Strict flag, to be written only while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b1;
      end else if (csr_wr_en) begin
         strict_ff <= csr_wr_data;
      end
   end

   // Escape state registers advance on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_TEXT;
         first_hex_ff <= 8'd0;
         aborted_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         first_hex_ff <= first_hex_in;
         aborted_ff   <= aborted_in;
      end
   end

   // Next state and the command for the current byte.
   always_comb begin
      mode_in      = mode_ff;
      first_hex_in = first_hex_ff;
      aborted_in   = aborted_ff;
      emit         = 1'b0;
      triple       = 1'b0;
      cut          = 1'b0;
      err          = ERR_NONE;
      out_val      = 8'd0;
      has_result   = 1'b0;
      digit        = hex_value(b);

      if (aborted_ff) begin
         // Drop everything up to the end of the string.
         if (eos) begin
            mode_in      = MODE_TEXT;
            first_hex_in = 8'd0;
            aborted_in   = 1'b0;
         end
      end else begin
         unique case (mode_ff)
            MODE_ESC: begin
               mode_in = MODE_TEXT;
               if (b == CHAR_X) begin
                  if (eos) cut = 1'b1;
                  else     mode_in = MODE_HEX0;
               end else if (b == CHAR_C) begin
                  if (eos) cut = 1'b1;
                  else     mode_in = MODE_CTRL;
               end else if (b == CHAR_N) begin
                  emit    = 1'b1;
                  out_val = CODE_NEWLINE;
               end else if (b == CHAR_R) begin
                  emit    = 1'b1;
                  out_val = CODE_RETURN;
               end else if (b == CHAR_T) begin
                  emit    = 1'b1;
                  out_val = CODE_TAB;
               end else begin
                  emit    = 1'b1;
                  out_val = b;
               end
            end
            MODE_HEX0: begin
               first_hex_in = digit;
               if (eos) begin
                  cut     = 1'b1;
                  mode_in = MODE_TEXT;
               end else begin
                  mode_in = MODE_HEX1;
               end
            end
            MODE_HEX1: begin
               mode_in = MODE_TEXT;
               if ((first_hex_ff > 8'd15 || digit > 8'd15) && strict_ff) begin
                  err = ERR_BAD_HEX;
               end else begin
                  emit    = 1'b1;
                  out_val = {first_hex_ff[3:0], 4'h0} + digit;
               end
            end
            MODE_CTRL: begin
               mode_in = MODE_TEXT;
               if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                  emit    = 1'b1;
                  out_val = ctrl_code(4'(b - CHAR_ZERO));
               end else if (b == CHAR_R) begin
                  emit    = 1'b1;
                  out_val = CODE_CTRL_R;
               end else if (b == CHAR_P) begin
                  emit    = 1'b1;
                  out_val = CODE_CTRL_P;
               end else if (b == CHAR_O) begin
                  emit    = 1'b1;
                  out_val = CODE_CTRL_O;
               end else begin
                  triple  = 1'b1;
                  out_val = b;
               end
            end
            default: begin
               mode_in = MODE_TEXT;
               if (b == CHAR_BACKSLASH) begin
                  if (eos) cut = 1'b1;
                  else     mode_in = MODE_ESC;
               end else begin
                  emit    = 1'b1;
                  out_val = b;
               end
            end
         endcase

         // A cut-off escape is only an error in strict mode.
         if (cut && strict_ff) begin
            err = ERR_INCOMPLETE;
         end
         if (err != ERR_NONE) begin
            mode_in = MODE_TEXT;
            if (!eos) aborted_in = 1'b1;
         end

         // The end of the string always produces at least a status beat.
         has_result = emit || triple || (err != ERR_NONE) || eos;

         if (eos) begin
            mode_in      = MODE_TEXT;
            first_hex_in = 8'd0;
            aborted_in   = 1'b0;
         end
      end

      push                 = fire && has_result;
      push_cmd.triple      = triple;
      push_cmd.data        = (emit || triple) ? out_val : 8'd0;
      push_cmd.byte_valid  = emit || triple;
      push_cmd.string_done = eos || (err != ERR_NONE);
      push_cmd.error_code  = err;
   end

   // While a string is being dropped the decoder sits in plain text mode.
   a_aborted_text: assert property (@(posedge clock) disable iff (reset)
      aborted_ff |-> mode_ff == MODE_TEXT)
      else $error("aborted string with escape state pending");

endmodule

`default_nettype wire

// ----- src/sec_queue.sv -----
// ---------------------------------------------------------------------------
// sec_queue: command queue
// Short register queue that decouples the classifier from the result
// sequencer so each side can stall on its own.
// ---------------------------------------------------------------------------
`default_nettype none

module sec_queue #(
   parameter int DEPTH = sec_pkg::SEC_QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire sec_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output logic                  head_valid,
   output sec_pkg::cmd_type      head_cmd,
   output logic                  full
);
   import sec_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_cmd   = entries_ff[rd_ptr_ff];

   // Pointer and fill count update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // The front end must hold off while the queue is full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("command pushed into a full queue");

endmodule

`default_nettype wire

// ----- src/sec_back.sv -----
// ---------------------------------------------------------------------------
// sec_back: result sequencer
// Expands each queued command into one or three result beats and holds
// them in the output register until the consumer takes them.
// ---------------------------------------------------------------------------
`default_nettype none

module sec_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire sec_pkg::cmd_type head_cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sec_pkg::rsp_type      rsp_data
);
   import sec_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       load;
   logic       last_beat;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The output register takes a new beat when it is empty or being drained.
   assign load      = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign last_beat = !head_cmd.triple || (phase_ff == 2'd2);
   assign pop       = load && last_beat;

   // Build the beat for the current command and phase.
   always_comb begin
      rsp_data_in.byte_valid  = head_cmd.byte_valid;
      rsp_data_in.run_last    = last_beat;
      rsp_data_in.string_done = head_cmd.string_done && last_beat;
      rsp_data_in.error_code  = head_cmd.error_code;
      if (head_cmd.triple && phase_ff == 2'd0) begin
         rsp_data_in.out_byte = CHAR_BACKSLASH;
      end else if (head_cmd.triple && phase_ff == 2'd1) begin
         rsp_data_in.out_byte = CHAR_C;
      end else begin
         rsp_data_in.out_byte = head_cmd.data;
      end

      phase_in = phase_ff;
      if (load) begin
         phase_in = last_beat ? 2'd0 : phase_ff + 2'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Only the three-byte pass-through leaves the phase counter off zero.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("phase counter out of range");

   a_phase_triple: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd0 |-> head_valid && head_cmd.triple)
      else $error("phase counter running without a pass-through command");

   // Beats that are not the last of a byte are always plain data.
   a_mid_beat_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.run_last
         |-> rsp_data_ff.byte_valid && rsp_data_ff.error_code == ERR_NONE
         && !rsp_data_ff.string_done)
      else $error("status beat in the middle of a pass-through");

endmodule

`default_nettype wire

// ----- src/string_escape_collapser.sv -----
// ---------------------------------------------------------------------------
// string_escape_collapser: backslash escape decoder for string literals
// Collapses escapes in a byte stream (hex, control, simple and unknown
// escapes) and reports incomplete or invalid escapes in strict mode.
// ---------------------------------------------------------------------------
//
//   Channel  | Ports                           | Beat
//   ---------+---------------------------------+------------------------------
//   input    | req_valid, req_stall, req_data  | one raw byte, end mark
//   result   | rsp_valid, rsp_stall, rsp_data  | one decoded byte or status
//   control  | csr_wr_en, csr_wr_data          | strict flag, reset to 1
//
// One input beat is accepted per cycle while req_stall is low; its first
// result passes through the queue and then leaves from the output register.
// An unknown control escape gives three result beats in turn;
// while the back end works through them the queue of QDEPTH commands
// fills and req_stall rises when it is full.
// Reset is synchronous and clears the escape state, queue and output valid.
// A stalled result holds in the output register; input flows until the queue is full.
// ---------------------------------------------------------------------------
`default_nettype none

module string_escape_collapser #(
   parameter int QDEPTH = sec_pkg::SEC_QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_wr_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sec_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sec_pkg::rsp_type      rsp_data
);
   import sec_pkg::*;

   logic    fire;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;
   logic    full;

   // Input beats are taken whenever the queue has room.
   assign req_stall = full;
   assign fire      = req_valid && !full;

   sec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .req_data    (req_data),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   sec_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .full       (full)
   );

   sec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- verif/string_escape_collapser_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// string_escape_collapser_tb: self-checking bench for the escape collapser
// Raw string bytes go in with random gaps, and results are taken with random
// stalls and one long hold. A behavioral decoder in the bench predicts every
// result beat, and each one is checked field by field as it leaves the block.
// Short directed strings come first, then random strings that are mostly
// well formed, with strict mode both on and off.
// ---------------------------------------------------------------------------
`default_nettype none

module string_escape_collapser_tb;
   import sec_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_REPORTS   = 10;
   localparam int HOLD_CYCLES   = 300;

   // Control codes for the digit forms of a control escape.
   localparam logic [7:0] CTRL_CODES [10] = '{
      8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h0B, 8'h0C, 8'h0E
   };

   logic    clock;
   logic    reset;
   logic    csr_wr_en;
   logic    csr_wr_data;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Decoder state mirrored by the bench.
   mode_type   next_mode;
   logic [7:0] held_digit;
   logic       dropping;
   logic       strict_mode;

   rsp_type    decoded_queue [$];
   logic [7:0] text_q [$];

   int beats_sent;
   int strings_sent;
   int results_seen;
   int mismatch_count;
   int cycle_count;
   int long_hold_req;
   bit src_idle_on;
   bit sink_idle_on;

   string_escape_collapser dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap or stall length: mostly none, sometimes short, rarely long.
   function automatic int draw_gap(input bit enabled);
      int roll;
      if (!enabled) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 0;
      end
      if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Value of a hex digit character; out-of-range values mark it invalid.
   function automatic logic [7:0] digit_of(input logic [7:0] ch);
      logic [7:0] folded;
      folded = (ch >= 8'd65 && ch <= 8'd90) ? (ch | 8'h20) : ch;
      return (folded >= 8'd97 && folded <= 8'd127) ? folded - 8'd87 : folded - 8'd48;
   endfunction

   function automatic rsp_type data_beat(input logic [7:0] value);
      rsp_type r;
      r = '0;
      r.out_byte   = value;
      r.byte_valid = 1'b1;
      return r;
   endfunction

   function automatic rsp_type status_beat(input err_type err);
      rsp_type r;
      r = '0;
      r.error_code = err;
      return r;
   endfunction

   // Decode one raw byte and queue the result beats it should produce.
   function automatic void decode_step(input logic [7:0] raw, input logic eos);
      rsp_type    outs [$];
      rsp_type    last;
      logic       cut;
      err_type    err;
      logic [7:0] d1;
      cut = 1'b0;
      err = ERR_NONE;

      // The rest of an aborted string is swallowed up to its end mark.
      if (dropping) begin
         if (eos) begin
            next_mode  = MODE_TEXT;
            held_digit = '0;
            dropping   = 1'b0;
         end
         return;
      end

      case (next_mode)
         MODE_ESC: begin
            next_mode = MODE_TEXT;
            if (raw == CHAR_X || raw == CHAR_C) begin
               if (eos) begin
                  cut = 1'b1;
               end else if (raw == CHAR_X) begin
                  next_mode = MODE_HEX0;
               end else begin
                  next_mode = MODE_CTRL;
               end
            end else if (raw == CHAR_N) begin
               outs.push_back(data_beat(CODE_NEWLINE));
            end else if (raw == CHAR_R) begin
               outs.push_back(data_beat(CODE_RETURN));
            end else if (raw == CHAR_T) begin
               outs.push_back(data_beat(CODE_TAB));
            end else begin
               outs.push_back(data_beat(raw));
            end
         end
         MODE_HEX0: begin
            held_digit = digit_of(raw);
            if (eos) begin
               cut       = 1'b1;
               next_mode = MODE_TEXT;
            end else begin
               next_mode = MODE_HEX1;
            end
         end
         MODE_HEX1: begin
            d1        = digit_of(raw);
            next_mode = MODE_TEXT;
            if ((held_digit > 8'd15 || d1 > 8'd15) && strict_mode) begin
               err = ERR_BAD_HEX;
            end else begin
               outs.push_back(data_beat({held_digit[3:0], 4'h0} + d1));
            end
         end
         MODE_CTRL: begin
            next_mode = MODE_TEXT;
            if (raw >= CHAR_ZERO && raw <= CHAR_NINE) begin
               outs.push_back(data_beat(CTRL_CODES[4'(raw - CHAR_ZERO)]));
            end else if (raw == CHAR_R) begin
               outs.push_back(data_beat(CODE_CTRL_R));
            end else if (raw == CHAR_P) begin
               outs.push_back(data_beat(CODE_CTRL_P));
            end else if (raw == CHAR_O) begin
               outs.push_back(data_beat(CODE_CTRL_O));
            end else begin
               // Unknown control escape passes through as three bytes.
               outs.push_back(data_beat(CHAR_BACKSLASH));
               outs.push_back(data_beat(CHAR_C));
               outs.push_back(data_beat(raw));
            end
         end
         default: begin
            next_mode = MODE_TEXT;
            if (raw == CHAR_BACKSLASH) begin
               if (eos) begin
                  cut = 1'b1;
               end else begin
                  next_mode = MODE_ESC;
               end
            end else begin
               outs.push_back(data_beat(raw));
            end
         end
      endcase

      // Errors give a status beat and drop the rest of the string.
      if (cut && strict_mode) begin
         err = ERR_INCOMPLETE;
      end
      if (err != ERR_NONE) begin
         outs.push_back(status_beat(err));
         next_mode = MODE_TEXT;
         if (!eos) begin
            dropping = 1'b1;
         end
      end
      if (eos && outs.size() == 0) begin
         outs.push_back(status_beat(ERR_NONE));
      end

      // Mark the last beat of this byte and, where it applies, of the string.
      if (outs.size() > 0) begin
         last = outs.pop_back();
         last.run_last = 1'b1;
         if (eos || err != ERR_NONE) begin
            last.string_done = 1'b1;
         end
         outs.push_back(last);
      end
      if (eos) begin
         next_mode  = MODE_TEXT;
         held_digit = '0;
         dropping   = 1'b0;
      end
      foreach (outs[i]) begin
         decoded_queue.push_back(outs[i]);
      end
   endfunction

   // Offer one raw byte and hold it until the block takes it.
   task automatic send_beat(input logic [7:0] raw, input logic eos);
      int gap;
      gap = draw_gap(src_idle_on);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{in_byte: raw, end_of_string: eos};
      forever begin
         @(posedge clock);
         if (!req_stall) begin
            break;
         end
      end
      decode_step(raw, eos);
      beats_sent++;
   endtask

   // Send text_q as one string, with the end mark on its last byte.
   task automatic send_string();
      foreach (text_q[i]) begin
         send_beat(text_q[i], i == text_q.size() - 1);
      end
      strings_sent++;
   endtask

   // Drop valid, then wait for every expected beat plus a short settle.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decoded_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) begin
         @(posedge clock);
      end
   endtask

   task automatic set_strict(input logic value);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      strict_mode = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hex digit character, usually valid in either case, sometimes any byte.
   function automatic logic [7:0] hex_char();
      int value;
      if ($urandom_range(0, 99) < 15) begin
         return 8'($urandom_range(0, 255));
      end
      value = $urandom_range(0, 15);
      if (value < 10) begin
         return CHAR_ZERO + 8'(value);
      end
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(value - 10);
   endfunction

   // Build and send one random string, mostly well-formed escapes.
   task automatic send_random_string();
      int         tokens;
      int         roll;
      logic [7:0] ch;
      text_q.delete();
      tokens = $urandom_range(1, 10);
      repeat (tokens) begin
         roll = $urandom_range(0, 99);
         if (roll < 25) begin
            ch = 8'($urandom_range(0, 255));
            if (ch == CHAR_BACKSLASH) begin
               ch = 8'h5B;
            end
            text_q.push_back(ch);
         end else if (roll < 42) begin
            case ($urandom_range(0, 3))
               0: ch = CHAR_N;
               1: ch = CHAR_R;
               2: ch = CHAR_T;
               default: begin
                  ch = 8'($urandom_range(0, 255));
                  if (ch == CHAR_X || ch == CHAR_C) begin
                     ch = CHAR_N;
                  end
               end
            endcase
            text_q.push_back(CHAR_BACKSLASH);
            text_q.push_back(ch);
         end else if (roll < 64) begin
            text_q.push_back(CHAR_BACKSLASH);
            text_q.push_back(CHAR_X);
            text_q.push_back(hex_char());
            text_q.push_back(hex_char());
         end else if (roll < 86) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
               ch = CHAR_ZERO + 8'($urandom_range(0, 9));
            end else if (roll < 65) begin
               ch = CHAR_R;
            end else if (roll < 73) begin
               ch = CHAR_P;
            end else if (roll < 80) begin
               ch = CHAR_O;
            end else begin
               ch = 8'($urandom_range(0, 255));
            end
            text_q.push_back(CHAR_BACKSLASH);
            text_q.push_back(CHAR_C);
            text_q.push_back(ch);
         end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
         end
      end
      // Some strings end in the middle of an escape.
      if ($urandom_range(0, 99) < 12) begin
         text_q.push_back(CHAR_BACKSLASH);
         case ($urandom_range(0, 3))
            1: text_q.push_back(CHAR_X);
            2: text_q.push_back(CHAR_C);
            3: begin
               text_q.push_back(CHAR_X);
               text_q.push_back(hex_char());
            end
            default: ;
         endcase
      end
      send_string();
   endtask

   task automatic test_plain_bytes();
      text_q = {8'h00, 8'hFF};
      send_string();
   endtask

   task automatic test_simple_escapes();
      // Newline and tab escapes, then an escaped backslash as the last byte.
      text_q = {CHAR_BACKSLASH, CHAR_N, CHAR_BACKSLASH, CHAR_T,
                CHAR_BACKSLASH, CHAR_BACKSLASH};
      send_string();
   endtask

   task automatic test_hex_escapes();
      // Upper and lower case digits: F then f gives 0xFF.
      text_q = {CHAR_BACKSLASH, CHAR_X, 8'h46, 8'h66};
      send_string();
   endtask

   task automatic test_control_escapes();
      // A table entry, then an unknown control escape at the end of string.
      text_q = {CHAR_BACKSLASH, CHAR_C, CHAR_NINE, CHAR_BACKSLASH, CHAR_C, 8'h7A};
      send_string();
   endtask

   task automatic test_strict_errors();
      // Invalid hex digit aborts the string, and the trailing byte is dropped.
      text_q = {CHAR_BACKSLASH, CHAR_X, 8'h67, 8'h31, 8'h41};
      send_string();
      // A lone backslash at the end is an incomplete escape.
      text_q = {CHAR_BACKSLASH};
      send_string();
   endtask

   task automatic test_lenient_errors();
      set_strict(1'b0);
      // Invalid hex still yields (16 * 16 + 1) mod 256.
      text_q = {CHAR_BACKSLASH, CHAR_X, 8'h67, 8'h31};
      send_string();
      // A cut control escape emits only the end-of-string status beat.
      text_q = {CHAR_BACKSLASH, CHAR_C};
      send_string();
   endtask

   task automatic test_random_strings(input logic strict_value, input bit idle_on,
                                      input int beat_goal);
      int first_beat;
      set_strict(strict_value);
      src_idle_on  = idle_on;
      sink_idle_on = idle_on;
      first_beat   = beats_sent;
      while (beats_sent - first_beat < beat_goal) begin
         send_random_string();
      end
   endtask

   task automatic test_output_hold();
      // Triple-beat escapes against a long receiver hold fill the block up.
      wait_idle();
      src_idle_on   = 1'b0;
      sink_idle_on  = 1'b0;
      long_hold_req = HOLD_CYCLES;
      text_q.delete();
      repeat (8) begin
         text_q.push_back(CHAR_BACKSLASH);
         text_q.push_back(CHAR_C);
         text_q.push_back(8'h7A);
      end
      send_string();
   endtask

   // Receiver: random stalls, plus a long hold when one is requested.
   initial begin : sink_ctrl
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req > 0) begin
            hold_left     = long_hold_req;
            long_hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = draw_gap(sink_idle_on);
            rsp_stall <= (stall_left > 0);
         end
      end
   end

   // Compare each accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (decoded_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("Unexpected result beat at %0t: byte=%02h valid=%b last=%b done=%b err=%0d",
                        $time, rsp_data.out_byte, rsp_data.byte_valid,
                        rsp_data.run_last, rsp_data.string_done, rsp_data.error_code);
            end
         end else begin
            want = decoded_queue.pop_front();
            if (rsp_data.out_byte !== want.out_byte ||
                rsp_data.byte_valid !== want.byte_valid ||
                rsp_data.run_last !== want.run_last ||
                rsp_data.string_done !== want.string_done ||
                rsp_data.error_code !== want.error_code) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("Mismatch at %0t: expected byte=%02h valid=%b last=%b done=%b err=%0d",
                           $time, want.out_byte, want.byte_valid, want.run_last,
                           want.string_done, want.error_code);
                  $display("                 actual   byte=%02h valid=%b last=%b done=%b err=%0d",
                           rsp_data.out_byte, rsp_data.byte_valid, rsp_data.run_last,
                           rsp_data.string_done, rsp_data.error_code);
               end
            end
         end
      end
   end

   // Watchdog on total run length.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d result beats outstanding",
               cycle_count, decoded_queue.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 1'b0;
      req_valid      = 1'b0;
      req_data       = '0;
      next_mode      = MODE_TEXT;
      held_digit     = '0;
      dropping       = 1'b0;
      strict_mode    = 1'b1;
      beats_sent     = 0;
      strings_sent   = 0;
      results_seen   = 0;
      mismatch_count = 0;
      long_hold_req  = 0;
      src_idle_on    = 1'b1;
      sink_idle_on   = 1'b1;
      repeat (11) begin
         @(posedge clock);
      end
      @(negedge clock);
      reset <= 1'b0;

      test_plain_bytes();
      test_simple_escapes();
      test_hex_escapes();
      test_control_escapes();
      test_strict_errors();
      test_lenient_errors();
      test_random_strings(1'b1, 1'b1, 150);
      test_random_strings(1'b0, 1'b1, 150);
      test_output_hold();
      test_random_strings(1'b1, 1'b0, 110);
      wait_idle();

      $display("Sent %0d strings (%0d raw beats) and checked %0d result beats,",
               strings_sent, beats_sent, results_seen);
      $display("with strict mode on and off, random gaps and stalls, and one long output hold.");
      if (mismatch_count == 0 && decoded_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d result beats failed their check", mismatch_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
src/sec_pkg.sv
src/sec_front.sv
src/sec_queue.sv
src/sec_back.sv
src/string_escape_collapser.sv
verif/string_escape_collapser_tb.sv
